@@ hw/rtl/tals_pkg.sv @@
// tals_pkg: mode, drive, cap command and fault codes for the two-axis lift sequencer
// plus the packed widths of the stream payloads
// no dependencies
`timescale 1ns / 1ps

package tals_pkg;

  // stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  // sequencer modes
  localparam logic [3:0] M_START        = 4'd0;
  localparam logic [3:0] M_OPENCAP      = 4'd1;
  localparam logic [3:0] M_CLOSECAP     = 4'd2;
  localparam logic [3:0] M_Y_RISING     = 4'd3;
  localparam logic [3:0] M_Y_MIDDLE     = 4'd4;
  localparam logic [3:0] M_Y_FALLING    = 4'd5;
  localparam logic [3:0] M_YZ_VERTICAL  = 4'd6;
  localparam logic [3:0] M_Z_VERTICAL   = 4'd7;
  localparam logic [3:0] M_Z_RISING     = 4'd8;
  localparam logic [3:0] M_Z_MIDDLE     = 4'd9;
  localparam logic [3:0] M_Z_FALLING    = 4'd10;
  localparam logic [3:0] M_PRESENTATION = 4'd11;
  localparam logic [3:0] M_UNDEFINED    = 4'd12;
  localparam logic [3:0] M_ERROR        = 4'd13;

  // motor drive codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_BACK = 2'd2;

  // cap command codes
  localparam logic [1:0] CAP_NONE  = 2'd0;
  localparam logic [1:0] CAP_OPEN  = 2'd1;
  localparam logic [1:0] CAP_CLOSE = 2'd2;

  // fault codes
  localparam logic [2:0] FLT_NONE            = 3'd0;
  localparam logic [2:0] FLT_OPEN_NOT_UP     = 3'd1;
  localparam logic [2:0] FLT_OPEN_ALREADY    = 3'd2;
  localparam logic [2:0] FLT_OPEN_FAILED     = 3'd3;
  localparam logic [2:0] FLT_CLOSE_NOT_DOWN  = 3'd4;
  localparam logic [2:0] FLT_CLOSE_ALREADY   = 3'd5;
  localparam logic [2:0] FLT_CLOSE_FAILED    = 3'd6;

  // one tick of qualified inputs
  typedef struct packed {
    logic cap_ok;
    logic z_vert_limit;
    logic z_end_limit;
    logic y_home_limit;
    logic y_top_limit;
    logic horiz_press;
    logic vert_press;
    logic halt_press;
    logic down_press;
    logic up_press;
  } tick_t;

endpackage

@@ hw/rtl/two_axis_lift_sequencer.sv @@
// two_axis_lift_sequencer: mode sequencer for a cap, a main axis and a second axis
// depends on tals_pkg
// Pipeline: a tick passes the input register, then the mode update writes the result
//   register that drives out_tvalid; a stalled output holds the tick between them.
// Throughput: one tick per cycle unless out_tready stalls the output; the mode update is a
//   combinational priority decode of the registered state; ticks flow at full rate.
// Reset: rst_n synchronous, active low; clears both pipeline valids and puts the
//   sequencer in the start mode with motors stopped, cap marks and fault cleared.
`timescale 1ns / 1ps

module two_axis_lift_sequencer
  import tals_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // bit 0 up_press, 1 down_press, 2 halt_press, 3 vert_press, 4 horiz_press,
  // 5 y_top_limit, 6 y_home_limit, 7 z_end_limit, 8 z_vert_limit, 9 cap_ok, rest zero
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // bits 3:0 mode, 5:4 main_drive, 7:6 second_drive, 9:8 cap_cmd, 12:10 fault,
  // rest zero
  output logic [OutDataW-1:0] out_tdata
);

  // pipeline control
  logic  in_valid_r;
  tick_t in_tick_r;
  logic  out_free;
  logic  step;

  assign out_free  = !out_tvalid || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_tick_r <= tick_t'(in_tdata[$bits(tick_t)-1:0]);
    end
  end

  // sequencer state
  logic [3:0] mode_r, mode_nxt;
  logic       going_up_r, going_up_nxt;
  logic       going_down_r, going_down_nxt;
  logic       halted_r, halted_nxt;
  logic       entry_r, entry_nxt;
  logic       cap_open_r, cap_open_nxt;
  logic       cap_closed_r, cap_closed_nxt;
  logic [1:0] main_drv_r, main_drv_nxt;
  logic [1:0] second_drv_r, second_drv_nxt;
  logic [2:0] fault_r, fault_nxt;
  logic [1:0] cap_cmd;

  // mode update, tests in priority order per mode
  always_comb begin
    mode_nxt       = mode_r;
    going_up_nxt   = going_up_r;
    going_down_nxt = going_down_r;
    halted_nxt     = halted_r;
    entry_nxt      = entry_r;
    cap_open_nxt   = cap_open_r;
    cap_closed_nxt = cap_closed_r;
    main_drv_nxt   = main_drv_r;
    second_drv_nxt = second_drv_r;
    fault_nxt      = fault_r;
    cap_cmd        = CAP_NONE;

    unique case (mode_r)
      M_START: begin
        if (in_tick_r.up_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt = 1'b1;
          mode_nxt  = M_OPENCAP;
        end else begin
          entry_nxt = 1'b0;
        end
      end
      M_OPENCAP: begin
        if (!going_up_r) begin
          mode_nxt  = M_ERROR;
          fault_nxt = FLT_OPEN_NOT_UP;
        end else if (cap_open_r) begin
          mode_nxt  = M_ERROR;
          fault_nxt = FLT_OPEN_ALREADY;
        end else begin
          cap_cmd = CAP_OPEN;
          if (in_tick_r.cap_ok) begin
            cap_open_nxt   = 1'b1;
            cap_closed_nxt = 1'b0;
            mode_nxt       = M_Y_RISING;
          end else begin
            mode_nxt  = M_ERROR;
            fault_nxt = FLT_OPEN_FAILED;
          end
        end
      end
      M_CLOSECAP: begin
        if (!going_down_r) begin
          mode_nxt  = M_ERROR;
          fault_nxt = FLT_CLOSE_NOT_DOWN;
        end else if (cap_closed_r) begin
          mode_nxt  = M_ERROR;
          fault_nxt = FLT_CLOSE_ALREADY;
        end else begin
          cap_cmd = CAP_CLOSE;
          if (in_tick_r.cap_ok) begin
            cap_closed_nxt = 1'b1;
            cap_open_nxt   = 1'b0;
            mode_nxt       = M_START;
          end else begin
            mode_nxt  = M_ERROR;
            fault_nxt = FLT_CLOSE_FAILED;
          end
        end
      end
      M_Y_RISING: begin
        if (in_tick_r.y_top_limit) begin
          main_drv_nxt = DRV_STOP;
          entry_nxt    = 1'b1;
          mode_nxt     = M_YZ_VERTICAL;
        end else if (in_tick_r.halt_press) begin
          main_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b001;
          entry_nxt    = 1'b1;
          mode_nxt     = M_Y_MIDDLE;
        end else if (in_tick_r.down_press) begin
          main_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt    = 1'b1;
          mode_nxt     = M_Y_FALLING;
        end else if (entry_r) begin
          entry_nxt    = 1'b0;
          main_drv_nxt = DRV_FWD;
        end
      end
      M_Y_MIDDLE: begin
        if (in_tick_r.up_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt = 1'b1;
          mode_nxt  = M_Y_RISING;
        end else if (in_tick_r.down_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt = 1'b1;
          mode_nxt  = M_Y_FALLING;
        end else begin
          entry_nxt = 1'b0;
        end
      end
      M_Y_FALLING: begin
        if (in_tick_r.y_home_limit) begin
          main_drv_nxt = DRV_STOP;
          entry_nxt    = 1'b1;
          mode_nxt     = M_CLOSECAP;
        end else if (in_tick_r.up_press) begin
          main_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt    = 1'b1;
          mode_nxt     = M_Y_RISING;
        end else if (in_tick_r.halt_press) begin
          main_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b001;
          entry_nxt    = 1'b1;
          mode_nxt     = M_Y_MIDDLE;
        end else if (entry_r) begin
          entry_nxt    = 1'b0;
          main_drv_nxt = DRV_BACK;
        end
      end
      M_YZ_VERTICAL: begin
        if (going_up_r) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else if (going_down_r) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Y_FALLING;
        end else if (entry_r) begin
          entry_nxt      = 1'b0;
          main_drv_nxt   = DRV_STOP;
          second_drv_nxt = DRV_STOP;
        end
      end
      M_Z_VERTICAL: begin
        if (in_tick_r.up_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else if (in_tick_r.down_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt = 1'b1;
          mode_nxt  = M_Y_FALLING;
        end else if (in_tick_r.horiz_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else if (entry_r) begin
          entry_nxt      = 1'b0;
          main_drv_nxt   = DRV_STOP;
          second_drv_nxt = DRV_STOP;
        end
      end
      M_Z_RISING: begin
        if (in_tick_r.z_end_limit) begin
          second_drv_nxt = DRV_STOP;
          entry_nxt      = 1'b1;
          mode_nxt       = M_PRESENTATION;
        end else if (in_tick_r.halt_press) begin
          second_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b001;
          entry_nxt      = 1'b1;
          mode_nxt       = M_Z_MIDDLE;
        end else if (in_tick_r.down_press) begin
          second_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt      = 1'b1;
          mode_nxt       = M_Z_FALLING;
        end else if (in_tick_r.vert_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_FALLING;
        end else if (entry_r) begin
          entry_nxt      = 1'b0;
          second_drv_nxt = DRV_FWD;
        end
      end
      M_Z_MIDDLE: begin
        if (in_tick_r.up_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else if (in_tick_r.down_press) begin
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_FALLING;
        end else if (in_tick_r.vert_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_FALLING;
        end else if (in_tick_r.horiz_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else begin
          entry_nxt = 1'b0;
        end
      end
      M_Z_FALLING: begin
        if (in_tick_r.z_vert_limit) begin
          second_drv_nxt = DRV_STOP;
          entry_nxt      = 1'b1;
          mode_nxt       = going_down_r ? M_YZ_VERTICAL : M_Z_VERTICAL;
        end else if (in_tick_r.up_press) begin
          second_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b100;
          entry_nxt      = 1'b1;
          mode_nxt       = M_Z_RISING;
        end else if (in_tick_r.halt_press) begin
          second_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b001;
          entry_nxt      = 1'b1;
          mode_nxt       = M_Z_MIDDLE;
        end else if (in_tick_r.horiz_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_RISING;
        end else if (entry_r) begin
          entry_nxt      = 1'b0;
          second_drv_nxt = DRV_BACK;
        end
      end
      M_PRESENTATION: begin
        if (in_tick_r.down_press) begin
          second_drv_nxt = DRV_STOP;
          {going_up_nxt, going_down_nxt, halted_nxt} = 3'b010;
          entry_nxt      = 1'b1;
          mode_nxt       = M_Z_FALLING;
        end else if (in_tick_r.vert_press) begin
          entry_nxt = 1'b1;
          mode_nxt  = M_Z_FALLING;
        end else if (entry_r) begin
          entry_nxt      = 1'b0;
          main_drv_nxt   = DRV_STOP;
          second_drv_nxt = DRV_STOP;
        end
      end
      // error, undefined and unused codes hold everything
      default: begin
      end
    endcase
  end

  // state registers, updated once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_START;
      going_up_r   <= 1'b0;
      going_down_r <= 1'b0;
      halted_r     <= 1'b0;
      entry_r      <= 1'b0;
      cap_open_r   <= 1'b0;
      cap_closed_r <= 1'b0;
      main_drv_r   <= DRV_STOP;
      second_drv_r <= DRV_STOP;
      fault_r      <= FLT_NONE;
    end else if (step) begin
      mode_r       <= mode_nxt;
      going_up_r   <= going_up_nxt;
      going_down_r <= going_down_nxt;
      halted_r     <= halted_nxt;
      entry_r      <= entry_nxt;
      cap_open_r   <= cap_open_nxt;
      cap_closed_r <= cap_closed_nxt;
      main_drv_r   <= main_drv_nxt;
      second_drv_r <= second_drv_nxt;
      fault_r      <= fault_nxt;
    end
  end

  // result register
  logic out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {3'b000, fault_nxt, cap_cmd, second_drv_nxt, main_drv_nxt, mode_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // halted only tracked for direction bookkeeping; keep it observable to checks
  // sticky error: a fault code is set exactly when the mode is error
  a_fault_means_error: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != FLT_NONE) == (mode_r == M_ERROR))
    else $error("fault code and error mode disagree");

  // error mode is left only by reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_ERROR) |=> (mode_r == M_ERROR))
    else $error("error mode left without reset");

  // at most one direction mark is set
  a_dir_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({going_up_r, going_down_r, halted_r}))
    else $error("direction marks overlap");

  // state moves only with a processed tick
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r) && $stable(fault_r))
    else $error("state changed without a processed tick");

endmodule

@@ dv/tb_two_axis_lift_sequencer.sv @@
// tb_two_axis_lift_sequencer: self-checking bench for the two-axis lift sequencer
// drives ticks on the input stream, predicts each status word and checks the output stream
// depends on tals_pkg and two_axis_lift_sequencer
`timescale 1ns / 1ps

module tb_two_axis_lift_sequencer;
  import tals_pkg::*;

  // one predicted status word
  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] main_drive;
    logic [1:0] second_drive;
    logic [1:0] cap_cmd;
    logic [2:0] fault;
  } lift_status_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // bit 0 up_press, 1 down_press, 2 halt_press, 3 vert_press, 4 horiz_press,
  // 5 y_top_limit, 6 y_home_limit, 7 z_end_limit, 8 z_vert_limit, 9 cap_ok, rest zero
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // bits 3:0 mode, 5:4 main_drive, 7:6 second_drive, 9:8 cap_cmd, 12:10 fault, rest zero
  logic [OutDataW-1:0] out_tdata;

  // predicted sequencer state
  logic [3:0] lift_mode     = M_START;
  logic       going_up      = 1'b0;
  logic       going_down    = 1'b0;
  logic       halted        = 1'b0;
  logic       entry_pending = 1'b0;
  logic       cap_open      = 1'b0;
  logic       cap_closed    = 1'b0;
  logic [1:0] main_drv      = DRV_STOP;
  logic [1:0] second_drv    = DRV_STOP;
  logic [2:0] fault_code    = FLT_NONE;

  lift_status_t expected_status[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_off_left  = 0;

  two_axis_lift_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequencer predictor
  // ---------------------------------------------------------------------------
  function automatic void steer(logic up, logic down, logic stop);
    going_up   = up;
    going_down = down;
    halted     = stop;
  endfunction

  function automatic void enter_mode(logic [3:0] m);
    entry_pending = 1'b1;
    lift_mode     = m;
  endfunction

  function automatic void trip(logic [2:0] code);
    lift_mode  = M_ERROR;
    fault_code = code;
  endfunction

  function automatic lift_status_t next_lift_status(tick_t t);
    lift_status_t r;
    logic [1:0]   cap;
    cap = CAP_NONE;
    case (lift_mode)
      M_START: begin
        if (t.up_press) begin
          steer(1'b1, 1'b0, 1'b0); enter_mode(M_OPENCAP);
        end else if (entry_pending) entry_pending = 1'b0;
      end
      M_OPENCAP: begin
        if (!going_up) trip(FLT_OPEN_NOT_UP);
        else if (cap_open) trip(FLT_OPEN_ALREADY);
        else begin
          cap = CAP_OPEN;
          if (t.cap_ok) begin
            cap_open   = 1'b1;
            cap_closed = 1'b0;
            lift_mode  = M_Y_RISING;
          end else trip(FLT_OPEN_FAILED);
        end
      end
      M_CLOSECAP: begin
        if (!going_down) trip(FLT_CLOSE_NOT_DOWN);
        else if (cap_closed) trip(FLT_CLOSE_ALREADY);
        else begin
          cap = CAP_CLOSE;
          if (t.cap_ok) begin
            cap_closed = 1'b1;
            cap_open   = 1'b0;
            lift_mode  = M_START;
          end else trip(FLT_CLOSE_FAILED);
        end
      end
      M_Y_RISING: begin
        if (t.y_top_limit) begin
          main_drv = DRV_STOP; enter_mode(M_YZ_VERTICAL);
        end else if (t.halt_press) begin
          main_drv = DRV_STOP; steer(1'b0, 1'b0, 1'b1); enter_mode(M_Y_MIDDLE);
        end else if (t.down_press) begin
          main_drv = DRV_STOP; steer(1'b0, 1'b1, 1'b0); enter_mode(M_Y_FALLING);
        end else if (entry_pending) begin
          entry_pending = 1'b0; main_drv = DRV_FWD;
        end
      end
      M_Y_MIDDLE: begin
        if (t.up_press) begin
          steer(1'b1, 1'b0, 1'b0); enter_mode(M_Y_RISING);
        end else if (t.down_press) begin
          steer(1'b0, 1'b1, 1'b0); enter_mode(M_Y_FALLING);
        end else if (entry_pending) entry_pending = 1'b0;
      end
      M_Y_FALLING: begin
        if (t.y_home_limit) begin
          main_drv = DRV_STOP; enter_mode(M_CLOSECAP);
        end else if (t.up_press) begin
          main_drv = DRV_STOP; steer(1'b1, 1'b0, 1'b0); enter_mode(M_Y_RISING);
        end else if (t.halt_press) begin
          main_drv = DRV_STOP; steer(1'b0, 1'b0, 1'b1); enter_mode(M_Y_MIDDLE);
        end else if (entry_pending) begin
          entry_pending = 1'b0; main_drv = DRV_BACK;
        end
      end
      M_YZ_VERTICAL: begin
        if (going_up) enter_mode(M_Z_RISING);
        else if (going_down) enter_mode(M_Y_FALLING);
        else if (entry_pending) begin
          entry_pending = 1'b0; main_drv = DRV_STOP; second_drv = DRV_STOP;
        end
      end
      M_Z_VERTICAL: begin
        if (t.up_press) begin
          steer(1'b1, 1'b0, 1'b0); enter_mode(M_Z_RISING);
        end else if (t.down_press) begin
          steer(1'b0, 1'b1, 1'b0); enter_mode(M_Y_FALLING);
        end else if (t.horiz_press) enter_mode(M_Z_RISING);
        else if (entry_pending) begin
          entry_pending = 1'b0; main_drv = DRV_STOP; second_drv = DRV_STOP;
        end
      end
      M_Z_RISING: begin
        if (t.z_end_limit) begin
          second_drv = DRV_STOP; enter_mode(M_PRESENTATION);
        end else if (t.halt_press) begin
          second_drv = DRV_STOP; steer(1'b0, 1'b0, 1'b1); enter_mode(M_Z_MIDDLE);
        end else if (t.down_press) begin
          second_drv = DRV_STOP; steer(1'b0, 1'b1, 1'b0); enter_mode(M_Z_FALLING);
        end else if (t.vert_press) enter_mode(M_Z_FALLING);
        else if (entry_pending) begin
          entry_pending = 1'b0; second_drv = DRV_FWD;
        end
      end
      M_Z_MIDDLE: begin
        if (t.up_press) begin
          steer(1'b1, 1'b0, 1'b0); enter_mode(M_Z_RISING);
        end else if (t.down_press) begin
          steer(1'b0, 1'b1, 1'b0); enter_mode(M_Z_FALLING);
        end else if (t.vert_press) enter_mode(M_Z_FALLING);
        else if (t.horiz_press) enter_mode(M_Z_RISING);
        else if (entry_pending) entry_pending = 1'b0;
      end
      M_Z_FALLING: begin
        if (t.z_vert_limit) begin
          second_drv = DRV_STOP;
          enter_mode(going_down ? M_YZ_VERTICAL : M_Z_VERTICAL);
        end else if (t.up_press) begin
          second_drv = DRV_STOP; steer(1'b1, 1'b0, 1'b0); enter_mode(M_Z_RISING);
        end else if (t.halt_press) begin
          second_drv = DRV_STOP; steer(1'b0, 1'b0, 1'b1); enter_mode(M_Z_MIDDLE);
        end else if (t.horiz_press) enter_mode(M_Z_RISING);
        else if (entry_pending) begin
          entry_pending = 1'b0; second_drv = DRV_BACK;
        end
      end
      M_PRESENTATION: begin
        if (t.down_press) begin
          second_drv = DRV_STOP; steer(1'b0, 1'b1, 1'b0); enter_mode(M_Z_FALLING);
        end else if (t.vert_press) enter_mode(M_Z_FALLING);
        else if (entry_pending) begin
          entry_pending = 1'b0; main_drv = DRV_STOP; second_drv = DRV_STOP;
        end
      end
      // error and undefined modes hold everything
      default: ;
    endcase
    r.mode         = lift_mode;
    r.main_drive   = main_drv;
    r.second_drive = second_drv;
    r.cap_cmd      = cap;
    r.fault        = fault_code;
    return r;
  endfunction

  // random tick; cap_ok is forced high in the cap modes so the run stays out of the error mode
  function automatic tick_t random_tick();
    tick_t t;
    int    pct;
    pct = ($urandom_range(0, 99) < 80) ? 20 : 50;
    t = '0;
    for (int b = 0; b < $bits(tick_t); b++) t[b] = ($urandom_range(0, 99) < pct);
    if (lift_mode == M_OPENCAP || lift_mode == M_CLOSECAP) t.cap_ok = 1'b1;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one tick per transfer, prediction at acceptance
  // ---------------------------------------------------------------------------
  task automatic send_tick(tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InDataW'(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_status.push_back(next_lift_status(t));
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, long hold-off on request, check each transfer
  // ---------------------------------------------------------------------------
  initial begin
    lift_status_t exp_s;
    lift_status_t got_s;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got_s.mode         = out_tdata[3:0];
        got_s.main_drive   = out_tdata[5:4];
        got_s.second_drive = out_tdata[7:6];
        got_s.cap_cmd      = out_tdata[9:8];
        got_s.fault        = out_tdata[12:10];
        if (expected_status.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected status word, expected none, actual %h", $time, out_tdata);
        end else begin
          exp_s = expected_status.pop_front();
          if (got_s.mode !== exp_s.mode) begin
            mismatch_count++;
            $display("%0t: mode expected %0d actual %0d", $time, exp_s.mode, got_s.mode);
          end
          if (got_s.main_drive !== exp_s.main_drive) begin
            mismatch_count++;
            $display("%0t: main_drive expected %0d actual %0d", $time,
                     exp_s.main_drive, got_s.main_drive);
          end
          if (got_s.second_drive !== exp_s.second_drive) begin
            mismatch_count++;
            $display("%0t: second_drive expected %0d actual %0d", $time,
                     exp_s.second_drive, got_s.second_drive);
          end
          if (got_s.cap_cmd !== exp_s.cap_cmd) begin
            mismatch_count++;
            $display("%0t: cap_cmd expected %0d actual %0d", $time,
                     exp_s.cap_cmd, got_s.cap_cmd);
          end
          if (got_s.fault !== exp_s.fault) begin
            mismatch_count++;
            $display("%0t: fault expected %0d actual %0d", $time, exp_s.fault, got_s.fault);
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a walk through several Y and Z modes, one button or switch at a time
  task automatic test_walk_through_modes();
    tick_t t;
    t = '0;                     send_tick(t);  // start, nothing pressed
    t = '0; t.up_press = 1'b1;  send_tick(t);  // to open cap
    t = '0; t.cap_ok = 1'b1;    send_tick(t);  // cap opens, Y rising
    t = '0;                     send_tick(t);  // main motor forward
    t = '0; t.halt_press = 1'b1; send_tick(t); // Y middle
    t = '0; t.up_press = 1'b1;  send_tick(t);  // Y rising again
    t = '0; t.y_top_limit = 1'b1; send_tick(t); // YZ vertical
    t = '0;                     send_tick(t);  // still going up, Z rising
    t = '0;                     send_tick(t);  // second motor forward
    t = '0; t.vert_press = 1'b1; send_tick(t); // Z falling
    t = '0;                     send_tick(t);  // second motor backward
    t = '0; t.z_vert_limit = 1'b1; send_tick(t); // Z vertical, not going down
    t = '0;                     send_tick(t);  // both motors stopped
    t = '0; t.horiz_press = 1'b1; send_tick(t); // Z rising
  endtask

  // every input high: the highest priority item wins in each mode
  task automatic test_all_inputs_high();
    tick_t t;
    t = '1;
    // presentation, Z falling, YZ vertical, Y falling, close cap, start, open cap, Y rising
    repeat (8) send_tick(t);
  endtask

  task automatic test_random_ticks(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_tick(random_tick());
  endtask

  // output held off for a long stretch while the input keeps offering ticks
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 120;
    repeat (60) send_tick(random_tick());
  endtask

  // a failed cap operation locks the sequencer in the error mode
  task automatic test_sticky_fault();
    logic [3:0] target;
    tick_t      t;
    int         guard;
    target = ($urandom_range(0, 1) == 0) ? M_OPENCAP : M_CLOSECAP;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    guard = 0;
    while (lift_mode != target && guard < 4000) begin
      send_tick(random_tick());
      guard++;
    end
    t = tick_t'(10'($urandom_range(0, 1023)));
    t.cap_ok = 1'b0;
    send_tick(t);
    // nothing moves any more
    repeat (40) send_tick(tick_t'(10'($urandom_range(0, 1023))));
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    int drain;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_walk_through_modes();
    test_all_inputs_high();
    test_random_ticks(500, 27, 59);
    test_random_ticks(500, 59, 27);
    test_random_ticks(500, 0, 0);
    test_output_backpressure();
    test_sticky_fault();

    in_tvalid <= 1'b0;
    recv_idle_pct = 0;
    while (expected_status.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 10) begin
      @(posedge clk);
      drain++;
    end

    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tals_pkg.sv
hw/rtl/two_axis_lift_sequencer.sv
dv/tb_two_axis_lift_sequencer.sv
